// ===== src/pnc_pkg.sv =====
// Shared widths, register indexes and result type for the positive neighbor count block.
package pnc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 5;
    localparam int CNT_W    = 4;
    localparam int NROWS_W  = 11;
    localparam int NCOLS_W  = 6;
    localparam int CFG_W    = 11;
    localparam int MAX_ROWS = 1024;

    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] neighbor_count;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             run_last;
        logic             frame_last;
    } result_t;

endpackage

// ===== src/pnc_window.sv =====
// Positive-neighbor count of one column from three row bit vectors.
module pnc_window #(
    parameter int MAX_COLS = 32
) (
    input  logic [MAX_COLS-1:0]       above,
    input  logic [MAX_COLS-1:0]       mid,
    input  logic [MAX_COLS-1:0]       below,
    input  logic [pnc_pkg::COL_W-1:0] col,
    output logic [pnc_pkg::CNT_W-1:0] count
);

    logic [MAX_COLS+1:0] above_ext;
    logic [MAX_COLS+1:0] mid_ext;
    logic [MAX_COLS+1:0] below_ext;
    logic [MAX_COLS+1:0] above_sh;
    logic [MAX_COLS+1:0] mid_sh;
    logic [MAX_COLS+1:0] below_sh;

    // bit 0 of the shifted vector is column col-1, bit 2 is col+1
    assign above_ext = {1'b0, above, 1'b0};
    assign mid_ext   = {1'b0, mid, 1'b0};
    assign below_ext = {1'b0, below, 1'b0};
    assign above_sh  = above_ext >> col;
    assign mid_sh    = mid_ext >> col;
    assign below_sh  = below_ext >> col;

    assign count = pnc_pkg::CNT_W'(above_sh[0]) + pnc_pkg::CNT_W'(above_sh[1])
                 + pnc_pkg::CNT_W'(above_sh[2]) + pnc_pkg::CNT_W'(mid_sh[0])
                 + pnc_pkg::CNT_W'(mid_sh[2])   + pnc_pkg::CNT_W'(below_sh[0])
                 + pnc_pkg::CNT_W'(below_sh[1]) + pnc_pkg::CNT_W'(below_sh[2]);

endmodule

// ===== src/positive_neighbor_count_3x3.sv =====
// Top level: raster line store in a three-row memory and per-row count sequencer.
//
//  channel   signals                                           dir
//  -------   -----------------------------------------------   ---
//  in        in_valid, in_ready, sample                        in
//  out       out_valid, out_ready, neighbor_count, out_row,    out
//            out_col, run_last, frame_last
//  cfg       cfg_we, cfg_index, cfg_data                       in
//
//  A request that does not end a row, or ends row 0 of a longer frame, leaves the block idle.
//  Any other row end goes through a memory read and a load, then one count per cycle while
//  the output is not stalled: num_cols, or 2*num_cols on a last row below row 0.
//  Reset clears positions and the row being built; memory rows are only read once written.
//  A stalled output holds the sequencer; input is taken while the last count waits.
module positive_neighbor_count_3x3 #(
    parameter int MAX_COLS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [pnc_pkg::SAMPLE_W-1:0] sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [pnc_pkg::CNT_W-1:0]        neighbor_count,
    output logic [pnc_pkg::ROW_W-1:0]        out_row,
    output logic [pnc_pkg::COL_W-1:0]        out_col,
    output logic                             run_last,
    output logic                             frame_last,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [pnc_pkg::CFG_W-1:0]        cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [pnc_pkg::NROWS_W-1:0]   num_rows_reg, num_rows_next;
    logic [pnc_pkg::NCOLS_W-1:0]   num_cols_reg, num_cols_next;
    logic [pnc_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [pnc_pkg::COL_W-1:0]     col_reg, col_next;
    logic [1:0]                    slot_reg, slot_next;
    logic [MAX_COLS-1:0]           cur_reg, cur_next;
    logic [MAX_COLS-1:0]           r1_reg, r1_next;
    logic [MAX_COLS-1:0]           r2_reg, r2_next;
    logic                          do_prev_reg, do_prev_next;
    logic                          do_last_reg, do_last_next;
    logic                          phase_reg, phase_next;
    logic [pnc_pkg::COL_W-1:0]     j_reg, j_next;
    logic                          out_valid_reg, out_valid_next;
    pnc_pkg::result_t              out_reg, out_next;

    logic [MAX_COLS-1:0]           line_mem [3];
    logic [MAX_COLS-1:0]           rd1_reg;
    logic [MAX_COLS-1:0]           rd2_reg;
    logic                          mem_we;
    logic [1:0]                    prev1;
    logic [1:0]                    prev2;

    logic [pnc_pkg::ROW_W-1:0]     rows_m1;
    logic [pnc_pkg::COL_W-1:0]     cols_m1;
    logic                          accept;
    logic                          row_end;
    logic                          last_row;
    logic [MAX_COLS-1:0]           cur_set;
    logic                          load_out;
    logic                          phase_end;
    logic                          run_end;
    logic [pnc_pkg::CNT_W-1:0]     count;

    always_comb
    begin
        if (num_rows_reg == '0)
            rows_m1 = '0;
        else if (num_rows_reg > pnc_pkg::NROWS_W'(pnc_pkg::MAX_ROWS))
            rows_m1 = pnc_pkg::ROW_W'(pnc_pkg::MAX_ROWS - 1);
        else
            rows_m1 = pnc_pkg::ROW_W'(num_rows_reg - 11'd1);

        if (num_cols_reg == '0)
            cols_m1 = '0;
        else if (num_cols_reg > pnc_pkg::NCOLS_W'(MAX_COLS))
            cols_m1 = pnc_pkg::COL_W'(MAX_COLS - 1);
        else
            cols_m1 = pnc_pkg::COL_W'(num_cols_reg - 6'd1);
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign row_end   = (col_reg == cols_m1);
    assign last_row  = (row_reg == rows_m1);
    assign cur_set   = (sample > 0) ? (cur_reg | (MAX_COLS'(1) << col_reg)) : cur_reg;
    assign mem_we    = accept && row_end;
    assign prev1     = (slot_reg == 2'd0) ? 2'd2 : slot_reg - 2'd1;
    assign prev2     = (slot_reg == 2'd0) ? 2'd1 : ((slot_reg == 2'd1) ? 2'd2 : 2'd0);
    assign load_out  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign phase_end = (j_reg == cols_m1);
    assign run_end   = phase_end && (phase_reg || !do_last_reg);

    pnc_window #(
        .MAX_COLS (MAX_COLS)
    ) u_window (
        .above (r2_reg),
        .mid   (r1_reg),
        .below (cur_reg),
        .col   (j_reg),
        .count (count)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[slot_reg] <= cur_set;
        rd1_reg <= line_mem[prev1];
        rd2_reg <= line_mem[prev2];
    end

    always_comb
    begin
        state_next     = state_reg;
        num_rows_next  = num_rows_reg;
        num_cols_next  = num_cols_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        slot_next      = slot_reg;
        cur_next       = cur_reg;
        r1_next        = r1_reg;
        r2_next        = r2_reg;
        do_prev_next   = do_prev_reg;
        do_last_next   = do_last_reg;
        phase_next     = phase_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_next = cur_set;
                    if (!row_end)
                        col_next = col_reg + 5'd1;
                    else
                    begin
                        do_prev_next = (row_reg != '0);
                        do_last_next = last_row;
                        if ((row_reg != '0) || last_row)
                            state_next = ST_LOAD;
                        else
                        begin
                            row_next  = row_reg + 10'd1;
                            slot_next = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
                            col_next  = '0;
                            cur_next  = '0;
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                j_next     = '0;
                state_next = ST_EMIT;
                if (do_prev_reg)
                begin
                    phase_next = 1'b0;
                    r1_next    = rd1_reg;
                    r2_next    = (row_reg >= 10'd2) ? rd2_reg : '0;
                end
                else
                begin
                    // first row is also the last: its own counts only
                    phase_next = 1'b1;
                    r2_next    = '0;
                    r1_next    = cur_reg;
                    cur_next   = '0;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next            = 1'b1;
                    out_next.neighbor_count   = count;
                    out_next.out_row          = phase_reg ? row_reg : row_reg - 10'd1;
                    out_next.out_col          = j_reg;
                    out_next.run_last         = run_end;
                    out_next.frame_last       = phase_reg && phase_end;
                    j_next                    = j_reg + 5'd1;
                    if (run_end)
                    begin
                        state_next = ST_IDLE;
                        col_next   = '0;
                        cur_next   = '0;
                        if (do_last_reg)
                        begin
                            row_next  = '0;
                            slot_next = '0;
                        end
                        else
                        begin
                            row_next  = row_reg + 10'd1;
                            slot_next = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
                        end
                    end
                    else if (phase_end)
                    begin
                        phase_next = 1'b1;
                        j_next     = '0;
                        r2_next    = r1_reg;
                        r1_next    = cur_reg;
                        cur_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                pnc_pkg::REG_NUM_ROWS: num_rows_next = cfg_data;
                pnc_pkg::REG_NUM_COLS: num_cols_next = cfg_data[pnc_pkg::NCOLS_W-1:0];
                default: ;
            endcase
            row_next  = '0;
            col_next  = '0;
            slot_next = '0;
            cur_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            num_rows_reg  <= 11'd1;
            num_cols_reg  <= 6'd1;
            row_reg       <= '0;
            col_reg       <= '0;
            slot_reg      <= '0;
            cur_reg       <= '0;
            do_prev_reg   <= 1'b0;
            do_last_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            num_rows_reg  <= num_rows_next;
            num_cols_reg  <= num_cols_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            slot_reg      <= slot_next;
            cur_reg       <= cur_next;
            do_prev_reg   <= do_prev_next;
            do_last_reg   <= do_last_next;
            phase_reg     <= phase_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r1_reg  <= r1_next;
        r2_reg  <= r2_next;
        out_reg <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign neighbor_count = out_reg.neighbor_count;
    assign out_row        = out_reg.out_row;
    assign out_col        = out_reg.out_col;
    assign run_last       = out_reg.run_last;
    assign frame_last     = out_reg.frame_last;

`ifndef SYNTHESIS
    a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> run_last)
        else $error("frame_last without run_last");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (neighbor_count <= 4'd8) && (out_col <= cols_m1))
        else $error("count or column out of range");

    a_mid_row_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !row_end |=> state_reg == ST_IDLE)
        else $error("mid-row request left idle");

    a_emit_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |=> state_reg == ST_EMIT && j_reg == '0)
        else $error("load not followed by emit");
`endif

endmodule

// ===== sim/neighbor_count_checker.sv =====
// Checker for the positive neighbor count block: predicts and compares every count.
module neighbor_count_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [pnc_pkg::SAMPLE_W-1:0] sample,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [pnc_pkg::CNT_W-1:0]           neighbor_count,
    input  logic [pnc_pkg::ROW_W-1:0]           out_row,
    input  logic [pnc_pkg::COL_W-1:0]           out_col,
    input  logic                                run_last,
    input  logic                                frame_last,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [pnc_pkg::CFG_W-1:0]           cfg_data,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]                  line_bits [3];
    logic [pnc_pkg::NROWS_W-1:0]  rows_reg;
    logic [pnc_pkg::NCOLS_W-1:0]  cols_reg;
    int                           row_at;
    int                           col_at;
    pnc_pkg::result_t             expected_counts [$];

    function automatic int active_rows();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > pnc_pkg::MAX_ROWS)
            return pnc_pkg::MAX_ROWS;
        return int'(rows_reg);
    endfunction

    function automatic int active_cols();
        if (cols_reg == 0)
            return 1;
        if (cols_reg > 32)
            return 32;
        return int'(cols_reg);
    endfunction

    function automatic int tally3(logic [31:0] bits, int j, bit with_center);
        int n;
        n = 0;
        if (j > 0 && bits[j-1])
            n++;
        if (with_center && bits[j])
            n++;
        if (j < 31 && bits[j+1])
            n++;
        return n;
    endfunction

    task automatic report_error(string what, int want, int got);
        fail_count++;
        $display("%0t ERROR %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic clear_frame();
        line_bits[0] = '0;
        line_bits[1] = '0;
        line_bits[2] = '0;
        row_at = 0;
        col_at = 0;
    endtask

    task automatic queue_row_counts(int row, logic [31:0] above, logic [31:0] mid,
                                    logic [31:0] below, int cols, bit frame_end);
        pnc_pkg::result_t r;
        for (int j = 0; j < cols; j++)
        begin
            r.neighbor_count = pnc_pkg::CNT_W'(tally3(above, j, 1'b1) + tally3(mid, j, 1'b0)
                                               + tally3(below, j, 1'b1));
            r.out_row        = pnc_pkg::ROW_W'(row);
            r.out_col        = pnc_pkg::COL_W'(j);
            r.run_last       = 1'b0;
            r.frame_last     = frame_end && (j == cols - 1);
            expected_counts.push_back(r);
        end
    endtask

    task automatic predict_counts(logic signed [pnc_pkg::SAMPLE_W-1:0] s);
        int          rows;
        int          cols;
        int          queued;
        bit          last_row;
        logic [31:0] mask;
        rows = active_rows();
        cols = active_cols();
        mask = (cols >= 32) ? 32'hFFFF_FFFF : ((32'd1 << cols) - 32'd1);
        if (!s[pnc_pkg::SAMPLE_W-1] && s != 0)
            line_bits[2][col_at] = 1'b1;
        line_bits[2] &= mask;
        if (col_at + 1 < cols)
        begin
            col_at++;
        end
        else
        begin
            queued   = expected_counts.size();
            last_row = (row_at + 1 >= rows);
            if (row_at >= 1)
                queue_row_counts(row_at - 1, (row_at >= 2) ? (line_bits[0] & mask) : 32'd0,
                                 line_bits[1] & mask, line_bits[2], cols, 1'b0);
            if (last_row)
                queue_row_counts(row_at, (row_at >= 1) ? (line_bits[1] & mask) : 32'd0,
                                 line_bits[2], 32'd0, cols, 1'b1);
            if (expected_counts.size() > queued)
                expected_counts[expected_counts.size() - 1].run_last = 1'b1;
            if (last_row)
            begin
                clear_frame();
            end
            else
            begin
                line_bits[0] = line_bits[1];
                line_bits[1] = line_bits[2];
                line_bits[2] = '0;
                row_at       = row_at + 1;
                col_at       = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pnc_pkg::result_t head;
        if (!rst_n)
        begin
            fail_count = 0;
            rows_reg = 1;
            cols_reg = 1;
            clear_frame();
            expected_counts.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == pnc_pkg::REG_NUM_ROWS)
                    rows_reg = cfg_data[pnc_pkg::NROWS_W-1:0];
                else
                    cols_reg = cfg_data[pnc_pkg::NCOLS_W-1:0];
                clear_frame();
            end
            if (out_valid && out_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    report_error("count with none predicted", 0, neighbor_count);
                end
                else
                begin
                    head = expected_counts.pop_front();
                    if (neighbor_count !== head.neighbor_count)
                        report_error($sformatf("neighbor_count row %0d col %0d",
                                               head.out_row, head.out_col),
                                     head.neighbor_count, neighbor_count);
                    if (out_row !== head.out_row)
                        report_error("out_row", head.out_row, out_row);
                    if (out_col !== head.out_col)
                        report_error("out_col", head.out_col, out_col);
                    if (run_last !== head.run_last)
                        report_error($sformatf("run_last row %0d col %0d",
                                               head.out_row, head.out_col),
                                     head.run_last, run_last);
                    if (frame_last !== head.frame_last)
                        report_error($sformatf("frame_last row %0d col %0d",
                                               head.out_row, head.out_col),
                                     head.frame_last, frame_last);
                end
            end
            if (in_valid && in_ready)
                predict_counts(sample);
            pending <= expected_counts.size();
        end
    end

endmodule

// ===== sim/positive_neighbor_count_3x3_tb.sv =====
// Testbench top for the positive neighbor count block: stimulus, flow control and verdict.
module positive_neighbor_count_3x3_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid;
    logic                                in_ready;
    logic signed [pnc_pkg::SAMPLE_W-1:0] sample;
    logic                                out_valid;
    logic                                out_ready;
    logic [pnc_pkg::CNT_W-1:0]           neighbor_count;
    logic [pnc_pkg::ROW_W-1:0]           out_row;
    logic [pnc_pkg::COL_W-1:0]           out_col;
    logic                                run_last;
    logic                                frame_last;
    logic                                cfg_we;
    logic                                cfg_index;
    logic [pnc_pkg::CFG_W-1:0]           cfg_data;

    int                                  fail_count;
    int                                  pending;
    int                                  idle_cycles = 0;
    bit                                  no_gaps = 1'b0;
    logic                                squeeze = 1'b0;
    logic                                holding = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    positive_neighbor_count_3x3 #(.MAX_COLS(32)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .neighbor_count (neighbor_count),
        .out_row        (out_row),
        .out_col        (out_col),
        .run_last       (run_last),
        .frame_last     (frame_last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    neighbor_count_checker count_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .neighbor_count (neighbor_count),
        .out_row        (out_row),
        .out_col        (out_col),
        .run_last       (run_last),
        .frame_last     (frame_last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // no progress on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [pnc_pkg::SAMPLE_W-1:0] draw_sample(int density);
        logic [pnc_pkg::SAMPLE_W-1:0] v;
        v = pnc_pkg::SAMPLE_W'($urandom);
        if ($urandom_range(0, 99) < 12)
        begin
            case ($urandom_range(0, 4))
                0: v = 16'h7FFF;
                1: v = 16'h8000;
                2: v = 16'h0001;
                3: v = 16'hFFFF;
                default: v = 16'h0000;
            endcase
        end
        else if ($urandom_range(0, 99) < density)
        begin
            v[pnc_pkg::SAMPLE_W-1] = 1'b0;
            if (v == 0)
                v = 16'h0080;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            v = '0;
        end
        else
        begin
            v[pnc_pkg::SAMPLE_W-1] = 1'b1;
        end
        return v;
    endfunction

    task automatic send_sample(logic signed [pnc_pkg::SAMPLE_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(logic idx, logic [pnc_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // all counts back, then room for a row end that emits nothing
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic run_phase(logic [pnc_pkg::CFG_W-1:0] rows_val,
                             logic [pnc_pkg::CFG_W-1:0] cols_val,
                             int count, int density);
        write_reg(pnc_pkg::REG_NUM_ROWS, rows_val);
        write_reg(pnc_pkg::REG_NUM_COLS, cols_val);
        repeat (count) send_sample(draw_sample(density));
        settle();
    endtask

    // result side: bursts of ready, random gaps, one long hold-off on request
    initial
    begin
        bit squeezed;
        squeezed = 1'b0;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (squeeze && !squeezed)
            begin
                squeezed = 1'b1;
                out_ready <= 1'b0;
                holding   <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding   <= 1'b0;
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            if (squeeze && !squeezed)
                continue;
            begin
                int g;
                g = pick_gap();
                if (g > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int                        random_items;
        int                        phase_no;
        int                        eff_r;
        int                        eff_c;
        int                        count;
        logic [pnc_pkg::CFG_W-1:0] rows_val;
        logic [pnc_pkg::CFG_W-1:0] cols_val;

        in_valid  <= 1'b0;
        sample    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= pnc_pkg::REG_NUM_ROWS;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 1x1 frames
        send_sample(16'sh0001);
        send_sample(16'sh8000);
        settle();

        // 3x3: center surrounded by positives, extremes around it
        write_reg(pnc_pkg::REG_NUM_ROWS, 11'd3);
        write_reg(pnc_pkg::REG_NUM_COLS, 11'd3);
        send_sample(16'sh0001);
        send_sample(16'sh7FFF);
        send_sample(16'sh0100);
        send_sample(16'sh2AAA);
        send_sample(16'sh8000);
        send_sample(16'sh5555);
        send_sample(16'sh0001);
        send_sample(16'sh0002);
        send_sample(16'sh0003);
        settle();

        // zero registers act as one
        write_reg(pnc_pkg::REG_NUM_ROWS, 11'd0);
        write_reg(pnc_pkg::REG_NUM_COLS, 11'd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        settle();

        // column count taken from the low bits of the write
        write_reg(pnc_pkg::REG_NUM_ROWS, 11'd1);
        write_reg(pnc_pkg::REG_NUM_COLS, 11'h7C3);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
        settle();

        // frame cut short, then restarted by rewriting the same value
        write_reg(pnc_pkg::REG_NUM_ROWS, 11'd2);
        write_reg(pnc_pkg::REG_NUM_COLS, 11'd3);
        repeat (4) send_sample(16'sh0040);
        settle();
        write_reg(pnc_pkg::REG_NUM_COLS, 11'd3);
        send_sample(16'shFFFF);
        send_sample(16'sh0001);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(16'sh8001);
        send_sample(16'sh7FFE);
        settle();

        random_items = 0;
        phase_no     = 0;
        while (random_items < 120)
        begin
            if (phase_no == 2)
            begin
                // hold the result side while requests keep coming
                no_gaps = 1'b1;
                squeeze <= 1'b1;
                write_reg(pnc_pkg::REG_NUM_ROWS, 11'd6);
                write_reg(pnc_pkg::REG_NUM_COLS, 11'd8);
                do @(posedge clk); while (!holding);
                repeat (48) send_sample(draw_sample(60));
                settle();
                count = 48;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: cols_val = pnc_pkg::CFG_W'($urandom_range(1, 6));
                    6: cols_val = 11'd32;
                    7: cols_val = pnc_pkg::CFG_W'($urandom_range(33, 63));
                    8: cols_val = pnc_pkg::CFG_W'($urandom_range(7, 31));
                    default: cols_val = 11'd0;
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: rows_val = pnc_pkg::CFG_W'($urandom_range(1, 5));
                    6: rows_val = 11'd0;
                    7: rows_val = pnc_pkg::CFG_W'($urandom_range(1024, 2047));
                    8: rows_val = pnc_pkg::CFG_W'($urandom_range(6, 12));
                    default: rows_val = pnc_pkg::CFG_W'($urandom_range(1, 3));
                endcase
                eff_r = (rows_val == 0) ? 1
                      : (rows_val > pnc_pkg::MAX_ROWS) ? pnc_pkg::MAX_ROWS : rows_val;
                eff_c = (cols_val[5:0] == 0) ? 1 : (cols_val[5:0] > 32) ? 32
                      : cols_val[5:0];
                if (eff_r * eff_c <= 48)
                    count = eff_r * eff_c * $urandom_range(1, 2);
                else
                    count = eff_c * $urandom_range(1, 3);
                if ($urandom_range(0, 4) == 0)
                    count = $urandom_range(1, count);
                no_gaps = ($urandom_range(0, 5) == 0);
                run_phase(rows_val, cols_val, count, $urandom_range(0, 100));
            end
            no_gaps = 1'b0;
            random_items += count;
            phase_no++;
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
src/pnc_pkg.sv
src/pnc_window.sv
src/positive_neighbor_count_3x3.sv
sim/neighbor_count_checker.sv
sim/positive_neighbor_count_3x3_tb.sv
